// File: rtl/umfp_pkg.sv
// Package: shared types and constants for the UDP market feed parser.
`default_nettype none
package umfp_pkg;

   localparam int MAX_FRAME_BYTES  = 2048;
   localparam int MSG_HEADER_BYTES = 3;
   localparam int POS_W            = $clog2(MAX_FRAME_BYTES + 1);
   localparam int LEN_W            = 12;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

   localparam logic [LEN_W-1:0] MIN_FRAME_RESET = 12'd42;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [7:0]  TYPE_CROSS    = 8'h51;
   localparam int          ETH_BYTES     = 14;
   localparam int          MIN_IP_BYTES  = 20;
   localparam int          UDP_HDR_BYTES = 8;
   localparam int          CROSS_MIN_LEN = 40;
   localparam int          SYM_OFF       = 11;
   localparam int          PRICE_OFF     = 19;
   localparam int          QTY_OFF       = 27;

   typedef enum logic [3:0] {
      ST_OK         = 4'd0,
      ST_BELOW_MIN  = 4'd1,
      ST_SHORT_HDR  = 4'd2,
      ST_NOT_UDP    = 4'd3,
      ST_BAD_IHL    = 4'd4,
      ST_UDP_TRUNC  = 4'd5,
      ST_OVERRUN    = 4'd6,
      ST_MSG_SHORT  = 4'd7,
      ST_MSG_EXCESS = 4'd8,
      ST_NOT_CROSS  = 4'd9,
      ST_CROSS_SHORT= 4'd10,
      ST_OVERSIZE   = 4'd11
   } status_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [63:0] symbol_bytes;
      logic [3:0]  symbol_length;
      logic [63:0] price_value;
      logic [31:0] quantity;
   } rsp_item_type;

   // Captured frame summary handed from the byte front end to the verdict stage.
   typedef struct packed {
      logic              oversize;
      logic [POS_W-1:0]  length;
      logic [5:0]        ip_header_bytes;
      logic [7:0]        ip_protocol;
      logic [15:0]       udp_length;
      logic [15:0]       message_length;
      logic [7:0]        msg_kind;
      logic [63:0]       symbol;
      logic [63:0]       price;
      logic [31:0]       quantity;
   } frame_sum_type;

endpackage
`default_nettype wire

// File: rtl/umfp_front.sv
// Front end: consume frame bytes and capture header and message fields.
`default_nettype none
module umfp_front
   import umfp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          take,
   input  wire req_item_type  item,
   output logic               sum_valid,
   output frame_sum_type      sum
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             over_ff, over_in;
   logic [5:0]       ihl_ff, ihl_in;
   logic [7:0]       proto_ff, proto_in;
   logic [15:0]      udp_ff, udp_in;
   logic [15:0]      mlen_ff, mlen_in;
   logic [7:0]       mtype_ff, mtype_in;
   logic [63:0]      sym_ff, sym_in;
   logic [63:0]      price_ff, price_in;
   logic [31:0]      qty_ff, qty_in;

   logic [POS_W:0]   udp_start;
   logic [POS_W:0]   pay_start;
   logic [POS_W:0]   pos_x;
   logic [POS_W:0]   p;
   logic             capt;
   logic [7:0]       b;

   always_comb begin
      b         = item.frame_byte;
      pos_x     = {1'b0, pos_ff};
      capt      = (pos_ff < POS_W'(MAX_FRAME_BYTES));
      pos_in    = pos_ff;
      over_in   = over_ff;
      ihl_in    = ihl_ff;
      proto_in  = proto_ff;
      udp_in    = udp_ff;
      mlen_in   = mlen_ff;
      mtype_in  = mtype_ff;
      sym_in    = sym_ff;
      price_in  = price_ff;
      qty_in    = qty_ff;
      udp_start = (POS_W+1)'(ETH_BYTES) + (POS_W+1)'(ihl_ff);
      pay_start = udp_start + (POS_W+1)'(UDP_HDR_BYTES);
      p         = pos_x - pay_start;
      if (!capt) begin
         over_in = 1'b1;
      end else begin
         pos_in = pos_ff + 1'b1;
         if (pos_x == (POS_W+1)'(ETH_BYTES)) ihl_in = {b[3:0], 2'b00};
         if (pos_x == (POS_W+1)'(ETH_BYTES + 9)) proto_in = b;
         if (pos_x == udp_start + (POS_W+1)'(4)) udp_in[15:8] = b;
         if (pos_x == udp_start + (POS_W+1)'(5)) udp_in[7:0] = b;
         if (pos_x >= pay_start) begin
            if (p == (POS_W+1)'(0)) mlen_in[15:8] = b;
            else if (p == (POS_W+1)'(1)) mlen_in[7:0] = b;
            else if (p == (POS_W+1)'(2)) mtype_in = b;
            if (p >= (POS_W+1)'(MSG_HEADER_BYTES + SYM_OFF) &&
                p < (POS_W+1)'(MSG_HEADER_BYTES + SYM_OFF + 8))
               sym_in = {sym_ff[55:0], b};
            if (p >= (POS_W+1)'(MSG_HEADER_BYTES + PRICE_OFF) &&
                p < (POS_W+1)'(MSG_HEADER_BYTES + PRICE_OFF + 8))
               price_in = {price_ff[55:0], b};
            if (p >= (POS_W+1)'(MSG_HEADER_BYTES + QTY_OFF + 4) &&
                p < (POS_W+1)'(MSG_HEADER_BYTES + QTY_OFF + 8))
               qty_in = {qty_ff[23:0], b};
         end
      end
      sum.oversize        = over_in;
      sum.length          = pos_in;
      sum.ip_header_bytes = ihl_in;
      sum.ip_protocol     = proto_in;
      sum.udp_length      = udp_in;
      sum.message_length  = mlen_in;
      sum.msg_kind        = mtype_in;
      sum.symbol          = sym_in;
      sum.price           = price_in;
      sum.quantity        = qty_in;
      sum_valid           = take && item.last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset || (take && item.last_byte)) begin
         pos_ff   <= '0;
         over_ff  <= 1'b0;
         ihl_ff   <= '0;
         proto_ff <= '0;
         udp_ff   <= '0;
         mlen_ff  <= '0;
         mtype_ff <= '0;
         sym_ff   <= '0;
         price_ff <= '0;
         qty_ff   <= '0;
      end else if (take) begin
         pos_ff   <= pos_in;
         over_ff  <= over_in;
         ihl_ff   <= ihl_in;
         proto_ff <= proto_in;
         udp_ff   <= udp_in;
         mlen_ff  <= mlen_in;
         mtype_ff <= mtype_in;
         sym_ff   <= sym_in;
         price_ff <= price_in;
         qty_ff   <= qty_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/umfp_queue.sv
// Short queue of frame summaries between front end and verdict stage.
`default_nettype none
module umfp_queue
   import umfp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  wire frame_sum_type wr_data,
   input  wire logic          rd_en,
   output frame_sum_type      rd_data,
   output logic               empty,
   output logic               full
);

   frame_sum_type   mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QPTR_W:0]   cnt_ff;

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign rd_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) wr_ff <= wr_ff + 1'b1;
         if (rd_en) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (QPTR_W+1)'(wr_en) - (QPTR_W+1)'(rd_en);
      end
   end

endmodule
`default_nettype wire

// File: rtl/umfp_back.sv
// Back end: judge a frame summary and hold the result item.
`default_nettype none
module umfp_back
   import umfp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [LEN_W-1:0] min_len,
   input  wire logic        q_empty,
   input  wire frame_sum_type q_data,
   output logic             q_pop,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output rsp_item_type     rsp_item
);

   logic         full_ff, full_in;
   rsp_item_type item_ff, item_in;
   status_type   st;
   logic [16:0]  udp_end;
   logic [15:0]  pay_len;
   logic [3:0]   kept;
   logic         load;

   always_comb begin
      udp_end = 17'(ETH_BYTES) + 17'(q_data.ip_header_bytes) + 17'(q_data.udp_length);
      pay_len = q_data.udp_length - 16'(UDP_HDR_BYTES);
      if (q_data.oversize) st = ST_OVERSIZE;
      else if (17'(q_data.length) < 17'(min_len)) st = ST_BELOW_MIN;
      else if (q_data.length < POS_W'(ETH_BYTES + MIN_IP_BYTES + UDP_HDR_BYTES))
         st = ST_SHORT_HDR;
      else if (q_data.ip_protocol != PROTO_UDP) st = ST_NOT_UDP;
      else if (q_data.ip_header_bytes < 6'(MIN_IP_BYTES)) st = ST_BAD_IHL;
      else if (ETH_BYTES + UDP_HDR_BYTES + 32'(q_data.ip_header_bytes) > 32'(q_data.length))
         st = ST_UDP_TRUNC;
      else if (q_data.udp_length < 16'(UDP_HDR_BYTES) || udp_end > 17'(q_data.length))
         st = ST_OVERRUN;
      else if (pay_len < 16'(MSG_HEADER_BYTES)) st = ST_MSG_SHORT;
      else if (pay_len < q_data.message_length) st = ST_MSG_EXCESS;
      else if (q_data.msg_kind != TYPE_CROSS) st = ST_NOT_CROSS;
      else if (q_data.message_length < 16'(CROSS_MIN_LEN)) st = ST_CROSS_SHORT;
      else st = ST_OK;

      // trim trailing blanks and zero bytes from the symbol; all blank keeps all eight
      kept = 4'd0;
      for (int i = 0; i < 8; i++) begin
         if (q_data.symbol[8*i +: 8] != 8'h20 && q_data.symbol[8*i +: 8] != 8'h00
             && kept == 4'd0)
            kept = 4'(8 - i);
      end
      if (kept == 4'd0) kept = 4'd8;

      load    = !q_empty && (!full_ff || rsp_pop);
      q_pop   = load;
      full_in = full_ff;
      item_in = item_ff;
      if (rsp_pop && full_ff) full_in = 1'b0;
      if (load) begin
         full_in = 1'b1;
         item_in.status = st;
         if (st == ST_OK) begin
            item_in.symbol_bytes  = q_data.symbol;
            item_in.symbol_length = kept;
            item_in.price_value   = q_data.price;
            item_in.quantity      = q_data.quantity;
         end else begin
            item_in.symbol_bytes  = '0;
            item_in.symbol_length = '0;
            item_in.price_value   = '0;
            item_in.quantity      = '0;
         end
      end
   end

   assign rsp_empty = !full_ff;
   assign rsp_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else       full_ff <= full_in;
      item_ff <= item_in;
   end

endmodule
`default_nettype wire

// File: rtl/udp_market_feed_cross_trade_parser_top.sv
// Top level: UDP market feed cross-trade parser.
// Throughput: one frame byte per cycle while full is low.
// A verdict passes from the edge that takes the last byte through the summary queue
// write and then the verdict register to the result ports.
// Up to four frame summaries plus one held result may wait; full rises when the queue fills.
// Reset (synchronous, active high) clears frame capture, queue and result;
// min_frame_length returns to 42.
`default_nettype none
module udp_market_feed_cross_trade_parser_top
   import umfp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire req_item_type req_item,
   output logic             empty,
   input  wire logic        pop,
   output rsp_item_type     rsp_item,
   input  wire logic        csr_write_enable,
   input  wire logic [LEN_W-1:0] csr_write_data
);

   logic [LEN_W-1:0] min_len_ff;
   logic             take;
   logic             sum_valid;
   frame_sum_type    sum;
   frame_sum_type    q_data;
   logic             q_empty, q_full, q_pop;

   // refuse bytes only while the summary queue has no room
   assign full = q_full;
   assign take = push && !q_full;

   always_ff @(posedge clock) begin
      if (reset) min_len_ff <= MIN_FRAME_RESET;
      else if (csr_write_enable) min_len_ff <= csr_write_data;
   end

   umfp_front u_front (
      .clock, .reset, .take, .item(req_item), .sum_valid, .sum
   );

   umfp_queue u_queue (
      .clock, .reset, .wr_en(sum_valid), .wr_data(sum),
      .rd_en(q_pop), .rd_data(q_data), .empty(q_empty), .full(q_full)
   );

   umfp_back u_back (
      .clock, .reset, .min_len(min_len_ff), .q_empty, .q_data, .q_pop,
      .rsp_empty(empty), .rsp_pop(pop), .rsp_item
   );

   a_ok_fields: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.status != ST_OK) |-> (rsp_item.quantity == '0 &&
       rsp_item.symbol_length == '0)) else $error("non-ok result carries fields");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_item))) else $error("result lost");
   a_len: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.status == ST_OK) |-> (rsp_item.symbol_length != '0 &&
       rsp_item.symbol_length <= 4'd8)) else $error("bad symbol length");

endmodule
`default_nettype wire
